>>> design/sv32ptw_pkg.sv
// Shared types and constants for the Sv32 page table walker.
// No dependencies; imported by sv32ptw_eval and sv32_page_table_walker.
`timescale 1ns / 1ps

package sv32ptw_pkg;

    // Input item selector carried on the slave-side tuser.
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_ENTRY   = 1'b1;

    // Access kinds of a translation request.
    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_EXEC  = 2'd2;

    // Fault classes.
    localparam logic FLT_ACCESS = 1'b0;
    localparam logic FLT_PAGE   = 1'b1;

    // XWR encodings of a table entry with special meaning.
    localparam logic [2:0] XWR_POINTER     = 3'b000;
    localparam logic [2:0] XWR_RESERVED_W  = 3'b010;
    localparam logic [2:0] XWR_RESERVED_WX = 3'b110;

    // Result kinds carried on the master-side tuser.
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

    typedef struct packed {
        logic        action;
        logic [31:0] virtual_address;
        logic [1:0]  access_kind;
        logic [31:0] table_entry;
        logic        bus_ok;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] read_address;
        logic [31:0] physical_address;
        logic        fault_kind;
        logic [1:0]  fault_access;
        logic [31:0] fault_value;
    } t_result;

    typedef struct packed {
        logic        busy;
        logic        level;
        logic [31:0] pending_address;
        logic [1:0]  pending_kind;
        logic [19:0] base_ppn;
    } t_walk_state;

endpackage

>>> design/sv32ptw_eval.sv
// Single-step evaluation of one walker item against the current walk state.
// Depends on sv32ptw_pkg for the item, result and state types.
`timescale 1ns / 1ps

module sv32ptw_eval import sv32ptw_pkg::*; (
    input  t_walk_state i_state,
    input  t_item       i_item,
    input  logic [19:0] i_root_ppn,
    output t_walk_state o_state,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [2:0] xwr;
    logic [2:0] need;
    logic       bad_entry;
    logic       misaligned;

    assign xwr        = i_item.table_entry[3:1];
    assign bad_entry  = !i_item.table_entry[0] || (xwr == XWR_RESERVED_W)
                        || (xwr == XWR_RESERVED_WX);
    assign misaligned = i_state.level && (i_item.table_entry[19:10] != 10'd0);

    always_comb begin
        case (i_state.pending_kind)
            ACC_READ:  need = 3'b001;
            ACC_WRITE: need = 3'b010;
            ACC_EXEC:  need = 3'b100;
            default:   need = 3'b000;
        endcase
    end

    always_comb begin
        o_state     = i_state;
        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_item.action == ACT_REQUEST) begin
            o_state.pending_address = i_item.virtual_address;
            o_state.pending_kind    = i_item.access_kind;
            o_state.base_ppn        = i_root_ppn;
            o_state.level           = 1'b1;
            o_state.busy            = 1'b1;
            o_res_valid             = 1'b1;
            o_res.kind              = KIND_READ;
            o_res.read_address      = {i_root_ppn, i_item.virtual_address[31:22], 2'b00};
        end else if (i_state.busy) begin
            o_res_valid = 1'b1;
            // Fault fields are filled in by default; a successful outcome overwrites them.
            o_res.kind         = KIND_FAULT;
            o_res.fault_access = i_state.pending_kind;
            o_res.fault_value  = i_state.pending_address;
            o_res.fault_kind   = FLT_PAGE;
            o_state.busy       = 1'b0;
            o_state.level      = 1'b1;
            if (!i_item.bus_ok) begin
                o_res.fault_kind = FLT_ACCESS;
            end else if (bad_entry) begin
                o_res.fault_kind = FLT_PAGE;
            end else if (xwr == XWR_POINTER) begin
                if (i_state.level) begin
                    o_res              = '0;
                    o_res.kind         = KIND_READ;
                    o_res.read_address = {i_item.table_entry[29:10],
                                          i_state.pending_address[21:12], 2'b00};
                    o_state.busy       = 1'b1;
                    o_state.level      = 1'b0;
                    o_state.base_ppn   = i_item.table_entry[29:10];
                end
            end else if (((need & xwr) != 3'b000) && !misaligned) begin
                o_res      = '0;
                o_res.kind = KIND_DONE;
                if (i_state.level) begin
                    o_res.physical_address = {i_item.table_entry[29:20],
                                              i_state.pending_address[21:0]};
                end else begin
                    o_res.physical_address = {i_item.table_entry[29:10],
                                              i_state.pending_address[11:0]};
                end
            end
        end
    end

endmodule

>>> design/sv32_page_table_walker.sv
// Sv32 page table walker top level: input register, step logic, result register.
// Depends on sv32ptw_pkg and sv32ptw_eval.
// Throughput: one beat per cycle while the master side does not stall, set by the
// single register-to-register step stage.
// Reset (synchronous, active low) idles the walk, empties both stages, clears the root.
`timescale 1ns / 1ps

module sv32_page_table_walker import sv32ptw_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write channel: root page number of the table.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [19:0]  i_cfg_data,
    // Slave side.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata fields from bit 0: virtual_address[31:0], access_kind[33:32],
    // table_entry[65:34], zero pad [71:66].
    input  logic [71:0]  i_s_axis_tdata,
    // tuser fields from bit 0: action[0], bus_ok[1].
    input  logic [1:0]   i_s_axis_tuser,
    // Master side.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata fields from bit 0: read_address[31:0], physical_address[63:32],
    // fault_kind[64], fault_access[66:65], fault_value[98:67], zero pad [103:99].
    output logic [103:0] o_m_axis_tdata,
    // tuser fields from bit 0: kind[1:0].
    output logic [1:0]   o_m_axis_tuser
);

    // Root page number register. The user must write it only while the walker is idle;
    // the block itself does not enforce this. The port is always ready.
    logic [19:0] r_root_ppn;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ppn <= '0;
        end else if (i_cfg_valid) begin
            r_root_ppn <= i_cfg_data;
        end
    end

    // Input register stage. The stage advances whenever the result register
    // is free or is being drained this cycle, so a stalled master only holds
    // back the pipeline, never drops or repeats a beat.
    logic        r_in_valid;
    t_item       r_in;
    logic        advance;
    logic        in_beat;

    assign advance         = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in.action          <= i_s_axis_tuser[0];
            r_in.virtual_address <= i_s_axis_tdata[31:0];
            r_in.access_kind     <= i_s_axis_tdata[33:32];
            r_in.table_entry     <= i_s_axis_tdata[65:34];
            r_in.bus_ok          <= i_s_axis_tuser[1];
        end
    end

    // Walk state and the step logic. The state only moves when the item in
    // the input register is consumed, which keeps beats strictly in order.
    t_walk_state r_state;
    t_walk_state n_state;
    logic        n_res_valid;
    t_result     n_res;
    logic        step;

    assign step = r_in_valid && advance;

    sv32ptw_eval u_eval (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_root_ppn  (r_root_ppn),
        .o_state     (n_state),
        .o_res_valid (n_res_valid),
        .o_res       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.busy  <= 1'b0;
            r_state.level <= 1'b1;
        end else if (step) begin
            r_state.busy  <= n_state.busy;
            r_state.level <= n_state.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_state.pending_address <= n_state.pending_address;
            r_state.pending_kind    <= n_state.pending_kind;
            r_state.base_ppn        <= n_state.base_ppn;
        end
    end

    // Result register. An entry beat that arrives with no walk in flight
    // produces nothing and simply leaves the register empty.
    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && n_res_valid) begin
            r_out <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {5'd0, r_out.fault_value, r_out.fault_access,
                              r_out.fault_kind, r_out.physical_address,
                              r_out.read_address};

endmodule

>>> sim/sv32ptw_tb_pkg.sv
// Scoreboard for the Sv32 page table walker testbench: walk predictor and result checker.
// Depends on sv32ptw_pkg for the item, result and kind types.
`timescale 1ns / 1ps

package sv32ptw_tb_pkg;
    import sv32ptw_pkg::*;

    class walk_checker;
        logic [19:0] root_ppn;
        logic        busy;
        logic        level;
        logic [31:0] pend_va;
        logic [1:0]  pend_kind;
        logic [31:0] base;
        t_result     awaited_results[$];
        int          mismatches;

        function new();
            root_ppn   = '0;
            busy       = 1'b0;
            level      = 1'b1;
            pend_va    = '0;
            pend_kind  = '0;
            base       = '0;
            mismatches = 0;
        endfunction

        function void load_root(logic [19:0] value);
            root_ppn = value;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // Read request for the entry that indexes the current table level.
        function t_result entry_read();
            t_result  r;
            logic [9:0] index;
            r = '0;
            index = level ? pend_va[31:22] : pend_va[21:12];
            r.kind = KIND_READ;
            r.read_address = base + {20'b0, index, 2'b00};
            return r;
        endfunction

        function t_result walk_fault(logic cls);
            t_result r;
            r = '0;
            r.kind = KIND_FAULT;
            r.fault_kind = cls;
            r.fault_access = pend_kind;
            r.fault_value = pend_va;
            busy  = 1'b0;
            level = 1'b1;
            return r;
        endfunction

        // Advances the walk by one accepted beat and queues the result it causes.
        function void accept_item(t_item it);
            t_result    r;
            logic [2:0] xwr;
            logic [2:0] need;
            logic       produces;
            r = '0;
            produces = 1'b0;
            xwr = it.table_entry[3:1];
            if (it.action == ACT_REQUEST) begin
                pend_va   = it.virtual_address;
                pend_kind = it.access_kind;
                base      = {root_ppn, 12'h000};
                level     = 1'b1;
                busy      = 1'b1;
                r = entry_read();
                produces = 1'b1;
            end else if (busy) begin
                produces = 1'b1;
                if (!it.bus_ok) begin
                    r = walk_fault(FLT_ACCESS);
                end else if (!it.table_entry[0] || xwr == XWR_RESERVED_W
                             || xwr == XWR_RESERVED_WX) begin
                    r = walk_fault(FLT_PAGE);
                end else if (xwr == XWR_POINTER) begin
                    if (!level) begin
                        r = walk_fault(FLT_PAGE);
                    end else begin
                        base  = {it.table_entry[29:10], 12'h000};
                        level = 1'b0;
                        r = entry_read();
                    end
                end else begin
                    case (pend_kind)
                        ACC_READ:  need = 3'b001;
                        ACC_WRITE: need = 3'b010;
                        ACC_EXEC:  need = 3'b100;
                        default:   need = 3'b000;
                    endcase
                    if ((need & xwr) == 3'b000) begin
                        r = walk_fault(FLT_PAGE);
                    end else if (level && it.table_entry[19:10] != '0) begin
                        r = walk_fault(FLT_PAGE);
                    end else begin
                        r.kind = KIND_DONE;
                        r.physical_address = level
                            ? {it.table_entry[29:20], pend_va[21:0]}
                            : {it.table_entry[29:10], pend_va[11:0]};
                        busy  = 1'b0;
                        level = 1'b1;
                    end
                end
            end
            if (produces)
                awaited_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s: expected %h, actual %h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result beat: kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            compare("kind", 32'(want.kind), 32'(got.kind));
            compare("read_address", want.read_address, got.read_address);
            compare("physical_address", want.physical_address, got.physical_address);
            compare("fault_kind", 32'(want.fault_kind), 32'(got.fault_kind));
            compare("fault_access", 32'(want.fault_access), 32'(got.fault_access));
            compare("fault_value", want.fault_value, got.fault_value);
        endfunction
    endclass

endpackage

>>> sim/tb_sv32_page_table_walker.sv
// Testbench for the Sv32 page table walker: directed and random walks, checked beat by beat.
// Depends on sv32ptw_pkg, sv32ptw_tb_pkg and the walker RTL.
`timescale 1ns / 1ps

module tb_sv32_page_table_walker;
    import sv32ptw_pkg::*;
    import sv32ptw_tb_pkg::*;

    localparam logic [1:0] ACC_UNDEFINED = 2'd3;
    localparam int ITEM_TARGET = 2000;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 4;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [19:0]  cfg_data = '0;
    logic         s_valid = 1'b0;
    logic [71:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_ready = 1'b0;
    logic         o_cfg_ready;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [103:0] o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    walk_checker ledger;
    int          src_quiet = 0;
    int          sink_quiet = 0;
    int          idle_cycles = 0;

    sv32_page_table_walker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Random wait per beat, with occasional stretches of back-to-back beats.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            quiet_left = $urandom_range(10, 60);
        return $urandom_range(0, 15);
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = draw_wait(src_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata <= {6'b0, it.table_entry, it.access_kind, it.virtual_address};
        s_tuser <= {it.bus_ok, it.action};
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        ledger.accept_item(it);
    endtask

    // Unused fields of each beat carry random bits so that they toggle too.
    task automatic send_request(input logic [31:0] va, input logic [1:0] acc);
        t_item it;
        it.action          = ACT_REQUEST;
        it.virtual_address = va;
        it.access_kind     = acc;
        it.table_entry     = $urandom;
        it.bus_ok          = 1'($urandom);
        send_item(it);
    endtask

    task automatic send_entry(input logic [31:0] pte, input logic ok);
        t_item it;
        it.action          = ACT_ENTRY;
        it.virtual_address = $urandom;
        it.access_kind     = 2'($urandom);
        it.table_entry     = pte;
        it.bus_ok          = ok;
        send_item(it);
    endtask

    // Root writes happen only with the walker drained.
    task automatic write_root(input logic [19:0] value);
        s_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        ledger.load_root(value);
    endtask

    // Table entry biased toward the interesting outcomes for the given level.
    function automatic logic [31:0] random_entry(input bit upper_level, input logic [1:0] acc);
        logic [31:0] pte;
        logic [2:0]  xwr;
        int          pick;
        pte  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return pte;
        pte[0] = 1'b1;
        if (pick < 12) begin
            pte[0] = 1'b0;
        end else if (pick < 18) begin
            pte[3:1] = ($urandom_range(0, 1) != 0) ? XWR_RESERVED_W : XWR_RESERVED_WX;
        end else if ((upper_level && pick < 45) || pick < 22) begin
            pte[3:1] = XWR_POINTER;
        end else begin
            xwr = 3'($urandom);
            if (pick >= 35) begin
                case (acc)
                    ACC_READ:  xwr[0] = 1'b1;
                    ACC_WRITE: xwr[1] = 1'b1;
                    ACC_EXEC:  xwr[2] = 1'b1;
                    default: ;
                endcase
            end
            if (xwr == XWR_POINTER)
                xwr = 3'b001;
            // Write without read is reserved; keep leaves legal here.
            if (xwr[1] && !xwr[0])
                xwr[0] = 1'b1;
            pte[3:1] = xwr;
            if (upper_level && $urandom_range(0, 9) != 0)
                pte[19:10] = '0;
        end
        return pte;
    endfunction

    // One walk: a request and the entries that a memory would return for it.
    task automatic random_walk(inout int count);
        logic [31:0] va;
        logic [31:0] pte;
        logic [1:0]  acc;
        logic        ok;
        int          depth;
        int          pick;
        pick = $urandom_range(0, 19);
        va = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        acc = ($urandom_range(0, 19) == 0) ? ACC_UNDEFINED : 2'($urandom_range(0, 2));
        send_request(va, acc);
        count++;
        // Sometimes the next request abandons this walk before any entry returns.
        if ($urandom_range(0, 19) == 0)
            return;
        for (depth = 0; depth < 2; depth++) begin
            pte = random_entry(depth == 0, acc);
            ok  = ($urandom_range(0, 24) != 0);
            send_entry(pte, ok);
            count++;
            if (!(ok && pte[0] && pte[3:1] == XWR_POINTER && depth == 0))
                break;
            if ($urandom_range(0, 24) == 0)
                break;
        end
        // Stray entry; ignored when the walk has ended.
        if ($urandom_range(0, 24) == 0)
            send_entry($urandom, 1'($urandom));
    endtask

    initial begin
        int items;
        int phase_start;
        int phase;
        ledger = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_root(20'hFFFFF);
        // Pointer then full RWX leaf at level 0, all address bits set.
        send_request(32'hFFFF_FFFF, ACC_READ);
        send_entry(32'hFFFF_FC01, 1'b1);
        send_entry(32'hFFFF_FFFF, 1'b1);
        // Aligned superpage leaf with write permission.
        send_request(32'h0000_0000, ACC_WRITE);
        send_entry(32'h3FF0_0007, 1'b1);
        // Misaligned superpage.
        send_request(32'h0040_0ABC, ACC_EXEC);
        send_entry(32'h0000_0409, 1'b1);
        // Bus error on the entry read.
        send_request(32'h8000_1000, ACC_READ);
        send_entry(32'hFFFF_FFFF, 1'b0);
        // Invalid entry.
        send_request(32'h1234_5678, ACC_EXEC);
        send_entry(32'hFFFF_FFFE, 1'b1);
        // Reserved write-only and write-execute encodings.
        send_request(32'hDEAD_BEEF, ACC_READ);
        send_entry(32'h0000_0005, 1'b1);
        send_request(32'h0BAD_F00D, ACC_WRITE);
        send_entry(32'h0000_000D, 1'b1);
        // Pointer at level 0.
        send_request(32'h0000_0FFF, ACC_READ);
        send_entry(32'h0000_0401, 1'b1);
        send_entry(32'h0000_0001, 1'b1);
        // Read-only leaf for a write.
        send_request(32'h7FFF_F000, ACC_WRITE);
        send_entry(32'h0000_0003, 1'b1);
        // Undefined access kind faults on any leaf.
        send_request(32'hAAAA_5555, ACC_UNDEFINED);
        send_entry(32'h0000_000F, 1'b1);
        // Entry with no walk in progress.
        send_entry(32'h0000_000F, 1'b1);
        // A second request abandons the first walk.
        send_request(32'h5555_AAAA, ACC_EXEC);
        send_request(32'hC000_0000, ACC_READ);
        send_entry(32'h2000_0003, 1'b1);

        write_root(20'h00000);
        items = 0;
        phase_start = 0;
        phase = 0;
        while (items < ITEM_TARGET) begin
            random_walk(items);
            if (items - phase_start >= 500) begin
                phase_start = items;
                phase++;
                write_root((phase == 2) ? 20'hFFFFF : 20'($urandom));
            end
        end

        s_valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result side ready with its own random stalls.
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(sink_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got.kind             = t_kind'(o_m_axis_tuser);
            got.read_address     = o_m_axis_tdata[31:0];
            got.physical_address = o_m_axis_tdata[63:32];
            got.fault_kind       = o_m_axis_tdata[64];
            got.fault_access     = o_m_axis_tdata[66:65];
            got.fault_value      = o_m_axis_tdata[98:67];
            ledger.check_result(got);
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
            || (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
